/* rtl/core/mrip_pkg.sv */
package mrip_pkg;

  localparam int unsigned PERIOD_W  = 24;
  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned KNOB_W    = 12;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned PADDR_W   = 2;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(125000);
  localparam logic [KNOB_W-1:0]   KNOB_RESET   = KNOB_W'(2000);
  localparam logic [KNOB_W-1:0]   DEADBAND     = KNOB_W'(2);
  localparam logic [PCT_W-1:0]    PCT_FULL     = PCT_W'(100);

  localparam logic [PADDR_W-1:0]  ADDR_PWM_PERIOD = PADDR_W'(0);

  typedef enum logic [1:0] {
    MODE_RUN_LEFT       = 2'd0,
    MODE_STOP_FOR_RIGHT = 2'd1,
    MODE_RUN_RIGHT      = 2'd2,
    MODE_STOP_FOR_LEFT  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    NOTICE_NONE     = 2'd0,
    NOTICE_STOPPING = 2'd1,
    NOTICE_RIGHT    = 2'd2,
    NOTICE_LEFT     = 2'd3
  } notice_t;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_RIGHT = 2'd1,
    REQ_LEFT  = 2'd2,
    REQ_SPARE = 2'd3
  } request_t;

endpackage

/* rtl/core/motor_reversal_interlock_pwm.sv */
// Direction-reversal interlock with PWM duty setting for a DC motor. Each accepted item is one
// control tick carrying an optional speed reading, an optional direction request and a knob
// sample, and it yields exactly one result item. The block is a two-stage pipeline: the item is
// captured in an input register, and once the result register is free the mode logic, the
// deadband test and a 12 x 24 bit and a 12 x 7 bit multiply load the result register and
// update the controller state. A new item is taken in every cycle while results are being
// taken. The PWM period register sits at byte address 0 of the configuration port and
// should only be written while no item is in flight.
module motor_reversal_interlock_pwm (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mrip_pkg::PADDR_W-1:0]   paddr,
  input  logic [mrip_pkg::PDATA_W-1:0]   pwdata,
  output logic [mrip_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_speed_valid,
  input  logic [mrip_pkg::SPEED_W-1:0]   in_speed_rpm,
  input  logic [1:0]                     in_direction_request,
  input  logic [mrip_pkg::KNOB_W-1:0]    in_knob_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_drive_right,
  output logic                           out_drive_left,
  output logic [mrip_pkg::PERIOD_W-1:0]  out_duty_match,
  output logic                           out_duty_load,
  output logic [mrip_pkg::PCT_W-1:0]     out_duty_percent,
  output logic [1:0]                     out_mode_now,
  output logic [1:0]                     out_notice,
  output logic                           out_pwm_forced_off
);
  import mrip_pkg::*;

  logic [PERIOD_W-1:0] period_r;
  logic                cfg_wr;

  logic                s1_vld_r;
  logic                s1_sv_r;
  logic [SPEED_W-1:0]  s1_spd_r;
  request_t            s1_req_r;
  logic [KNOB_W-1:0]   s1_knob_r;

  mode_t               mode_r, mode_nxt;
  logic                want_right_r, want_right_nxt;
  logic                want_left_r, want_left_nxt;
  logic [SPEED_W-1:0]  held_speed_r, held_speed_nxt;
  logic [KNOB_W-1:0]   held_knob_r, held_knob_nxt;

  logic                advance;
  logic                apply;
  logic                use_knob;
  logic [KNOB_W-1:0]   sample;
  logic [KNOB_W-1:0]   diff;
  logic                load;
  logic [KNOB_W+PERIOD_W-1:0] prod;
  logic [KNOB_W+PCT_W-1:0]    pct_prod;
  logic                dr, dl, forced;
  notice_t             notice;
  logic                wr_req, wl_req;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_PWM_PERIOD);
  assign prdata = (paddr == ADDR_PWM_PERIOD) ? PDATA_W'(period_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (cfg_wr) begin
      period_r <= pwdata[PERIOD_W-1:0];
    end
  end

  // Handshake.
  assign advance  = s1_vld_r && (!out_valid || out_ready);
  assign in_ready = !s1_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sv_r   <= in_speed_valid;
      s1_spd_r  <= in_speed_rpm;
      s1_req_r  <= request_t'(in_direction_request);
      s1_knob_r <= in_knob_sample;
    end
  end

  // Controller step.
  always_comb begin
    held_speed_nxt = s1_sv_r ? s1_spd_r : held_speed_r;
    wr_req = want_right_r;
    wl_req = want_left_r;
    if (s1_req_r == REQ_RIGHT) begin
      wr_req = 1'b1;
      wl_req = 1'b0;
    end else if (s1_req_r == REQ_LEFT) begin
      wr_req = 1'b0;
      wl_req = 1'b1;
    end
    want_right_nxt = wr_req;
    want_left_nxt  = wl_req;
    mode_nxt = mode_r;
    dr       = 1'b0;
    dl       = 1'b0;
    notice   = NOTICE_NONE;
    forced   = 1'b0;
    apply    = 1'b0;
    use_knob = 1'b0;
    unique case (mode_r)
      MODE_RUN_LEFT: begin
        if (wr_req) begin
          if (held_speed_nxt == '0) begin
            mode_nxt = MODE_RUN_RIGHT;
            dr       = 1'b1;
            notice   = NOTICE_RIGHT;
          end else begin
            mode_nxt = MODE_STOP_FOR_RIGHT;
            notice   = NOTICE_STOPPING;
            apply    = 1'b1;
            forced   = 1'b1;
          end
          want_right_nxt = 1'b0;
        end else begin
          apply         = 1'b1;
          use_knob      = 1'b1;
          dl            = 1'b1;
          want_left_nxt = 1'b0;
        end
      end
      MODE_STOP_FOR_RIGHT: begin
        if (held_speed_nxt == '0) begin
          mode_nxt = MODE_RUN_RIGHT;
          dr       = 1'b1;
          notice   = NOTICE_RIGHT;
        end else begin
          apply  = 1'b1;
          forced = 1'b1;
        end
      end
      MODE_RUN_RIGHT: begin
        if (wl_req) begin
          if (held_speed_nxt == '0) begin
            mode_nxt = MODE_RUN_LEFT;
            dl       = 1'b1;
            notice   = NOTICE_LEFT;
          end else begin
            mode_nxt = MODE_STOP_FOR_LEFT;
            notice   = NOTICE_STOPPING;
            apply    = 1'b1;
            forced   = 1'b1;
          end
          want_left_nxt = 1'b0;
        end else begin
          apply          = 1'b1;
          use_knob       = 1'b1;
          dr             = 1'b1;
          want_right_nxt = 1'b0;
        end
      end
      MODE_STOP_FOR_LEFT: begin
        if (held_speed_nxt == '0) begin
          mode_nxt = MODE_RUN_LEFT;
          dl       = 1'b1;
          notice   = NOTICE_LEFT;
        end else begin
          apply  = 1'b1;
          forced = 1'b1;
        end
      end
    endcase
  end

  // Deadband test and duty computation.
  assign sample   = use_knob ? s1_knob_r : '0;
  assign diff     = (sample > held_knob_r) ? (sample - held_knob_r) : (held_knob_r - sample);
  assign load     = apply && (diff > DEADBAND);
  assign prod     = (KNOB_W+PERIOD_W)'(sample) * (KNOB_W+PERIOD_W)'(period_r);
  assign pct_prod = (KNOB_W+PCT_W)'(sample) * (KNOB_W+PCT_W)'(PCT_FULL);
  assign held_knob_nxt = apply ? sample : held_knob_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_RUN_LEFT;
      want_right_r <= 1'b0;
      want_left_r  <= 1'b0;
      held_speed_r <= '0;
      held_knob_r  <= KNOB_RESET;
    end else if (advance) begin
      mode_r       <= mode_nxt;
      want_right_r <= want_right_nxt;
      want_left_r  <= want_left_nxt;
      held_speed_r <= held_speed_nxt;
      held_knob_r  <= held_knob_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_drive_right    <= dr;
      out_drive_left     <= dl;
      out_duty_load      <= load;
      out_duty_match     <= load ? prod[KNOB_W +: PERIOD_W] : '0;
      out_duty_percent   <= load ? pct_prod[KNOB_W +: PCT_W] : '0;
      out_mode_now       <= mode_nxt;
      out_notice         <= notice;
      out_pwm_forced_off <= forced;
    end
  end

endmodule

/* rtl/core/mrip_checker.sv */
module mrip_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_drive_right,
  input logic                           out_drive_left,
  input logic [mrip_pkg::PERIOD_W-1:0]  out_duty_match,
  input logic                           out_duty_load,
  input logic [mrip_pkg::PCT_W-1:0]     out_duty_percent,
  input logic [1:0]                     out_mode_now,
  input logic [1:0]                     out_notice,
  input logic                           out_pwm_forced_off
);
  import mrip_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_duty_match)
      && $stable(out_mode_now) && $stable(out_notice))
    else $error("result item changed while stalled");

  a_pins_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_drive_right && out_drive_left))
    else $error("both drive pins active");

  a_forced_pins_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pwm_forced_off |-> !out_drive_right && !out_drive_left
      && (out_mode_now == MODE_STOP_FOR_RIGHT || out_mode_now == MODE_STOP_FOR_LEFT))
    else $error("drive active while PWM forced off");

  a_notice_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_notice == NOTICE_RIGHT |->
      out_mode_now == MODE_RUN_RIGHT && out_drive_right && !out_duty_load)
    else $error("switch to right inconsistent");

  a_idle_duty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_duty_load |-> out_duty_match == '0 && out_duty_percent == '0)
    else $error("duty fields set without load");

endmodule

bind motor_reversal_interlock_pwm mrip_checker u_mrip_checker (.*);
